// File: design/pbf_pkg.sv
// shared types and constants for the partitioned bloom filter
// no dependencies
package pbf_pkg;
  localparam logic [63:0] PRIME64 = 64'hFFFF_FFFF_FFFF_FFC5;
  localparam int unsigned CFG_W = 17;
  localparam logic [0:0] REG_HASH_COUNT = 1'b0;
  localparam logic [0:0] REG_PART_BITS  = 1'b1;
  localparam logic OP_ADD = 1'b1;
endpackage

// File: design/pbf_mod.sv
// bit-serial 64-bit modulo by a 17-bit divisor, one quotient bit per cycle
// depends on nothing
module pbf_mod (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [16:0] divisor,
  output logic        done,
  output logic [16:0] remainder
);
  logic [63:0] num_r, num_nxt;
  logic [17:0] rem_r, rem_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt, done_r, done_nxt;
  logic [17:0] sh;

  always_comb begin
    sh       = {rem_r[16:0], num_r[63]};
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = 7'd64;
      run_nxt = 1'b1;
    end else if (run_r) begin
      num_nxt = {num_r[62:0], 1'b0};
      rem_nxt = (sh >= {1'b0, divisor}) ? sh - {1'b0, divisor} : sh;
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r[16:0];
endmodule

// File: design/partitioned_bloom_filter_top.sv
// partitioned bloom filter top: sequencer, bitmap memory and item counter
// per item, each probe steps through the hash, modulo start, modulo wait, address, read and check
// states; up to k probes on test and k more to set bits on a new add, then the result strobes
// throughput set by the shared bit-serial modulo unit; one item at a time, busy meanwhile
// after reset the bitmap is cleared one word a cycle (busy high)
// result strobes for one cycle; the receiver cannot stall
module partitioned_bloom_filter_top
  import pbf_pkg::*;
#(
  parameter int unsigned BITMAP_BITS = 65536,
  parameter int unsigned MAX_HASHES  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [63:0] in_hash_word_0,
  input  logic [63:0] in_hash_word_1,
  input  logic [63:0] in_hash_word_2,
  input  logic [63:0] in_hash_word_3,
  output logic        out_valid,
  output logic        out_present,
  output logic        out_added,
  output logic [31:0] out_item_count,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);
  localparam int unsigned WORDS = (BITMAP_BITS + 63) / 64;
  localparam int unsigned AW    = $clog2(BITMAP_BITS);
  localparam int unsigned WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned KW    = $clog2(MAX_HASHES + 1);
  localparam int unsigned IW    = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_MODSTART, S_MODWAIT, S_ADDR, S_READ, S_CHECK, S_DONE
  } state_t;

  state_t      state_r;
  logic [4:0]  hcount_r;
  logic [16:0] pbits_r;
  logic        op_r;
  logic [63:0] w0_r, w1_r, w2_r, w3_r;
  logic [IW-1:0] idx_r;
  logic [KW-1:0] k_r;
  logic        setpass_r, present_r, added_r, valid_r;
  logic [31:0] count_r;
  logic [63:0] hash_r, prod;
  logic [16:0] m_r;
  logic [AW-1:0] addr_r;
  logic [WAW-1:0] clr_r;
  logic [63:0] mem [WORDS];
  logic [63:0] rd_r;
  logic [WAW-1:0] waddr;
  logic [5:0]  bsel;
  logic        mod_start, mod_done;
  logic [16:0] mod_rem;
  logic [32:0] full_addr;
  logic [4:0]  kclip;

  assign kclip = (hcount_r == 5'd0) ? 5'd1 :
                 ({27'd0, hcount_r} > MAX_HASHES) ? 5'(MAX_HASHES) : hcount_r;
  assign prod  = 64'(idx_r) * w3_r;
  assign waddr = (WORDS > 1) ? WAW'(addr_r >> 6) : '0;
  assign bsel  = (AW >= 6) ? 6'(addr_r) : 6'(addr_r);
  // probe address i*m + rem, wrapped to bitmap size
  assign full_addr = 33'(idx_r) * 33'(m_r) + 33'(mod_rem);
  assign mod_start = (state_r == S_MODSTART);

  pbf_mod u_mod (
    .clk(clk), .rst_n(rst_n), .start(mod_start), .dividend(hash_r),
    .divisor(m_r), .done(mod_done), .remainder(mod_rem)
  );

  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) mem[clr_r] <= '0;
    else if (state_r == S_CHECK && setpass_r) mem[waddr] <= rd_r | (64'd1 << bsel);
    rd_r <= mem[waddr];
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r <= in_op;
      w0_r <= in_hash_word_0; w1_r <= in_hash_word_1;
      w2_r <= in_hash_word_2; w3_r <= in_hash_word_3;
    end
    if (state_r == S_HASH) begin
      unique case (idx_r)
        IW'(0):  hash_r <= w0_r;
        IW'(1):  hash_r <= w1_r;
        IW'(2):  hash_r <= w2_r;
        IW'(3):  hash_r <= w3_r;
        default: hash_r <= w1_r + ((prod >= PRIME64) ? prod - PRIME64 : prod);
      endcase
    end
    if (state_r == S_MODWAIT && mod_done) addr_r <= AW'(full_addr);
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      hcount_r <= 5'd4;
      pbits_r  <= 17'd16384;
      count_r  <= '0;
      valid_r  <= 1'b0;
      idx_r    <= '0;
      k_r      <= '0;
      m_r      <= 17'd1;
      setpass_r <= 1'b0;
      present_r <= 1'b0;
      added_r  <= 1'b0;
    end else begin
      valid_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == REG_HASH_COUNT) hcount_r <= cfg_wdata[4:0];
        else pbits_r <= cfg_wdata;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + WAW'(1);
          if (clr_r == WAW'(WORDS - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (start) begin
          k_r       <= KW'(kclip);
          m_r       <= (pbits_r == 17'd0) ? 17'd1 : pbits_r;
          idx_r     <= '0;
          setpass_r <= 1'b0;
          state_r   <= S_HASH;
        end
        S_HASH:     state_r <= S_MODSTART;
        S_MODSTART: state_r <= S_MODWAIT;
        S_MODWAIT:  if (mod_done) state_r <= S_ADDR;
        S_ADDR:     state_r <= S_READ;
        S_READ:     state_r <= S_CHECK;
        S_CHECK: begin
          if (!setpass_r && !rd_r[bsel]) begin
            // a clear bit: not present
            present_r <= 1'b0;
            if (op_r == OP_ADD) begin
              setpass_r <= 1'b1; idx_r <= '0; state_r <= S_HASH;
            end else begin
              added_r <= 1'b0; state_r <= S_DONE;
            end
          end else if (KW'(idx_r) == k_r - KW'(1)) begin
            if (setpass_r) begin
              added_r <= 1'b1;
              if (count_r != '1) count_r <= count_r + 32'd1;
            end else begin
              present_r <= 1'b1; added_r <= 1'b0;
            end
            state_r <= S_DONE;
          end else begin
            idx_r <= idx_r + IW'(1); state_r <= S_HASH;
          end
        end
        S_DONE: begin
          valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = valid_r;
  assign out_present    = present_r;
  assign out_added      = added_r;
  assign out_item_count = count_r;
endmodule

// File: dv/tb_partitioned_bloom_filter_top.sv
// self-checking testbench for partitioned_bloom_filter_top: a directed and a random mix
// of tests and adds over several probe-count and partition-size settings
// depends on pbf_pkg and the partitioned_bloom_filter_top rtl
module tb_partitioned_bloom_filter_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pbf_pkg::*;

  localparam int unsigned MAP_BITS = 65536;
  localparam int unsigned PROBES_MAX = 16;

  typedef struct packed {
    logic [63:0] w0;
    logic [63:0] w1;
    logic [63:0] w2;
    logic [63:0] w3;
  } key_t;

  typedef struct packed {
    logic op;
    key_t key;
  } query_t;

  typedef struct packed {
    logic        present;
    logic        added;
    logic [31:0] count;
  } verdict_t;

  logic clk, rst_n;
  logic start, busy;
  logic in_op;
  logic [63:0] in_hash_word_0, in_hash_word_1, in_hash_word_2, in_hash_word_3;
  logic out_valid, out_present, out_added;
  logic [31:0] out_item_count;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  partitioned_bloom_filter_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_hash_word_0(in_hash_word_0), .in_hash_word_1(in_hash_word_1),
    .in_hash_word_2(in_hash_word_2), .in_hash_word_3(in_hash_word_3),
    .out_valid(out_valid), .out_present(out_present), .out_added(out_added),
    .out_item_count(out_item_count),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // shadow copy of the filter
  bit          shadow_map [MAP_BITS];
  logic [31:0] shadow_count;
  logic [4:0]  shadow_k;
  logic [16:0] shadow_m;

  query_t   pending_queries[$];
  verdict_t expected_verdicts[$];
  key_t     key_pool[$];
  int       fails;
  int       n_checked, n_present, n_added;
  bit       gappy, hold_send;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [15:0] probe_bit(key_t key, int unsigned i, logic [63:0] m);
    logic [63:0] h, p;
    case (i)
      0: h = key.w0;
      1: h = key.w1;
      2: h = key.w2;
      3: h = key.w3;
      default: begin
        p = 64'(i) * key.w3;
        if (p >= PRIME64) p = p - PRIME64;
        h = key.w1 + p;
      end
    endcase
    return 16'((64'(i) * m + h % m) % 64'(MAP_BITS));
  endfunction

  function automatic verdict_t filter_lookup_update(query_t q);
    int unsigned k;
    logic [63:0] m;
    verdict_t v;
    k = (shadow_k == 0) ? 1 : ((shadow_k > PROBES_MAX) ? PROBES_MAX : shadow_k);
    m = (shadow_m == 0) ? 64'd1 : 64'(shadow_m);
    v.present = 1'b1;
    v.added = 1'b0;
    for (int unsigned i = 0; i < k; i++)
      if (!shadow_map[probe_bit(q.key, i, m)]) v.present = 1'b0;
    if (q.op == OP_ADD && !v.present) begin
      for (int unsigned i = 0; i < k; i++) shadow_map[probe_bit(q.key, i, m)] = 1'b1;
      if (shadow_count != 32'hFFFF_FFFF) shadow_count++;
      v.added = 1'b1;
    end
    v.count = shadow_count;
    return v;
  endfunction

  // driver: start stays high across back-to-back beats
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_op <= 1'b0;
      {in_hash_word_0, in_hash_word_1, in_hash_word_2, in_hash_word_3} <= '0;
    end else if (!start || !busy) begin
      if (start)
        expected_verdicts.push_back(filter_lookup_update({in_op, in_hash_word_0,
          in_hash_word_1, in_hash_word_2, in_hash_word_3}));
      if (pending_queries.size() > 0 && !hold_send &&
          !(gappy && $urandom_range(99) < 18)) begin
        query_t q;
        q = pending_queries.pop_front();
        start <= 1'b1;
        in_op <= q.op;
        {in_hash_word_0, in_hash_word_1, in_hash_word_2, in_hash_word_3} <= q.key;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_verdicts.size() == 0) begin
        $error("result beat with nothing expected");
        fails++;
      end else begin
        verdict_t e;
        e = expected_verdicts.pop_front();
        n_checked++;
        if (e.present) n_present++;
        if (e.added) n_added++;
        if (out_present !== e.present) begin
          $error("present: expected %0d actual %0d", e.present, out_present);
          fails++;
        end
        if (out_added !== e.added) begin
          $error("added: expected %0d actual %0d", e.added, out_added);
          fails++;
        end
        if (out_item_count !== e.count) begin
          $error("item_count: expected %0d actual %0d", e.count, out_item_count);
          fails++;
        end
      end
    end
  end

  function automatic logic [63:0] rand64();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 64'($urandom_range(255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic query_t random_query();
    query_t q;
    q.op = 1'($urandom_range(1));
    if (key_pool.size() > 0 && $urandom_range(99) < 45) begin
      q.key = key_pool[$urandom_range(key_pool.size() - 1)];
      // near miss: one word disturbed
      if ($urandom_range(4) == 0)
        case ($urandom_range(3))
          0: q.key.w0 = rand64();
          1: q.key.w1 = rand64();
          2: q.key.w2 = rand64();
          default: q.key.w3 = rand64();
        endcase
    end else begin
      q.key = {rand64(), rand64(), rand64(), rand64()};
      if (q.op == OP_ADD) begin
        key_pool.push_back(q.key);
        if (key_pool.size() > 200) void'(key_pool.pop_front());
      end
    end
    return q;
  endfunction

  task automatic wait_drained();
    while (pending_queries.size() > 0 || start || expected_verdicts.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_HASH_COUNT) shadow_k = val[4:0];
    else shadow_m = val[16:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(int k, int m, int n);
    wait_drained();
    write_reg(REG_HASH_COUNT, CFG_W'(k));
    write_reg(REG_PART_BITS, CFG_W'(m));
    key_pool.delete();
    for (int i = 0; i < n; i++) pending_queries.push_back(random_query());
    wait_drained();
  endtask

  task automatic push_query(logic op, key_t key);
    pending_queries.push_back({op, key});
  endtask

  initial begin
    key_t ones, zeros, mixed;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    fails = 0;
    n_checked = 0;
    n_present = 0;
    n_added = 0;
    gappy = 1'b0;
    hold_send = 1'b0;
    shadow_count = '0;
    shadow_k = 5'd4;
    shadow_m = 17'd16384;
    ones = '1;
    zeros = '0;
    mixed = {64'h8000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFC4,
             64'h0123_4567_89AB_CDEF, 64'hFFFF_FFFF_FFFF_FFC5};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset settings: test, add, re-test, re-add of the extremes
    push_query(1'b0, zeros);
    push_query(OP_ADD, zeros);
    push_query(1'b0, zeros);
    push_query(OP_ADD, zeros);
    push_query(1'b0, ones);
    push_query(OP_ADD, ones);
    push_query(OP_ADD, ones);
    push_query(1'b0, ones);
    push_query(OP_ADD, mixed);
    push_query(1'b0, mixed);
    push_query(1'b0, {ones.w0, zeros.w1, ones.w2, zeros.w3});
    wait_drained();
    // zero probe count and zero partition size, then over-range probe count with wrap
    write_reg(REG_HASH_COUNT, '0);
    write_reg(REG_PART_BITS, '0);
    push_query(1'b0, mixed);
    push_query(OP_ADD, ones);
    push_query(OP_ADD, mixed);
    push_query(1'b0, zeros);
    wait_drained();
    write_reg(REG_HASH_COUNT, CFG_W'(31));
    write_reg(REG_PART_BITS, CFG_W'(131071));
    push_query(OP_ADD, mixed);
    push_query(1'b0, mixed);
    push_query(OP_ADD, ones);
    push_query(1'b0, ones);
    push_query(OP_ADD, {zeros.w0, ones.w1, zeros.w2, ones.w3});
    wait_drained();

    // random part; first phase without gaps
    run_phase(4, 16384, 150);
    gappy = 1'b1;
    run_phase(1, 1, 60);
    run_phase(0, 0, 40);
    run_phase(31, 65536, 60);
    run_phase(16, 131071, 50);
    // pause sending midway until everything is back
    wait_drained();
    write_reg(REG_HASH_COUNT, CFG_W'(4));
    write_reg(REG_PART_BITS, CFG_W'(16384));
    for (int i = 0; i < 400; i++) pending_queries.push_back(random_query());
    while (pending_queries.size() > 200) @(posedge clk);
    hold_send = 1'b1;
    while (expected_verdicts.size() > 0 || start) @(posedge clk);
    hold_send = 1'b0;
    wait_drained();
    run_phase(2, 300, 400);
    run_phase(3, 4096, 400);
    run_phase(8, 1000, 150);
    run_phase(5, 64, 150);

    wait_drained();
    repeat (300) @(posedge clk);
    $display("covered %0d results (%0d present, %0d new adds) over ten filter settings",
             n_checked, n_present, n_added);
    if (fails == 0 && expected_verdicts.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
